FILE: src/bmc_pkg.sv
// Shared types, codes and bracket tables for the bracket matcher/completer.
package bmc_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [2:0] KIND_CLOSE    = 3'd0;
    localparam logic [2:0] KIND_CORRUPT  = 3'd1;
    localparam logic [2:0] KIND_BALANCED = 3'd2;
    localparam logic [2:0] KIND_DISCARD  = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW = 3'd4;

    localparam logic [7:0] OPEN_CHARS  [4] = '{8'h28, 8'h5B, 8'h7B, 8'h3C};
    localparam logic [7:0] CLOSE_CHARS [4] = '{8'h29, 8'h5D, 8'h7D, 8'h3E};

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] code;
    } brk_t;

    function automatic brk_t bracket_decode(input logic [7:0] sym);
        brk_t r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            if (sym == OPEN_CHARS[i]) begin
                r.is_open = 1'b1;
                r.code    = 2'(i);
            end
            if (sym == CLOSE_CHARS[i]) begin
                r.is_close = 1'b1;
                r.code     = 2'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] closer_of(input logic [1:0] code);
        return CLOSE_CHARS[code];
    endfunction

endpackage

FILE: src/bracket_matcher_completer_core.sv
// Bracket matcher and completer: stack of open brackets in a synchronous memory.
//
// Input channel (s_valid/s_ready): one character per item in s_symbol, or a line
// end when s_line_end is 1 (s_symbol is then ignored).
// Result channel (m_valid/m_ready): kind, character and last per result item.
// Openers are pushed, matching closers pop, anything else reports one corrupt
// item and the rest of the line is dropped; a full stack reports overflow.
// At line end a clean line drains its completion closers top first, an empty
// stack gives one balanced item, a failed line one discarded item.
// Sequencing: a character's stack memory read happens as it is accepted in S_IDLE,
// the update in S_EXEC; its result, if any, is registered there and appears in the cycle after.
// A line end drains one closer per cycle from the memory port while output is free.
// The stack is one single-port-read, single-port-write memory of STACK_DEPTH
// two-bit entries; its contents need no clearing, so there is no init pass.
// Reset (aresetn low at a clock edge) empties the stack and the output register.
// A stalled receiver holds the current result; the block waits until it frees.
module bracket_matcher_completer_core #(
    parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_symbol,
    input  logic       s_line_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_character,
    output logic       m_last
);
    import bmc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   drain_reg, drain_next;
    logic            failed_reg, failed_next;
    logic [7:0]      sym_reg, sym_next;
    logic            end_reg, end_next;

    logic            m_valid_reg, m_valid_next;
    logic [2:0]      m_kind_reg, m_kind_next;
    logic [7:0]      m_character_reg, m_character_next;
    logic            m_last_reg, m_last_next;

    logic [1:0]      stack_mem [STACK_DEPTH];
    logic [1:0]      rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;
    logic [1:0]      wr_data;

    brk_t            dec;
    logic            out_free;
    logic            full;
    logic            match;
    logic            need_emit;
    logic            go_drain;
    logic [CW-1:0]   count_m1;
    logic [CW-1:0]   drain_m1;
    logic [CW-1:0]   drain_m2;

    assign dec      = bracket_decode(sym_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign full     = count_reg >= CW'(STACK_DEPTH);
    assign match    = dec.is_close && (count_reg != '0) && (rd_data_reg == dec.code);
    assign go_drain = end_reg && !failed_reg && (count_reg != '0);
    assign count_m1 = count_reg - CW'(1);
    assign drain_m1 = drain_reg - CW'(1);
    assign drain_m2 = drain_reg - CW'(2);

    always_comb begin
        if (end_reg) begin
            need_emit = !go_drain;
        end else if (failed_reg) begin
            need_emit = 1'b0;
        end else if (dec.is_open) begin
            need_emit = full;
        end else begin
            need_emit = !match;
        end
    end

    always_comb begin
        if (state_reg == S_DRAIN) begin
            rd_addr = out_free ? drain_m2[AW-1:0] : drain_m1[AW-1:0];
        end else begin
            rd_addr = count_m1[AW-1:0];
        end
    end

    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = dec.code;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (need_emit && !out_free) begin
                    state_next = S_EXEC;
                end else if (go_drain) begin
                    state_next = S_DRAIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (out_free && (drain_reg == CW'(1))) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next       = count_reg;
        drain_next       = drain_reg;
        failed_next      = failed_reg;
        sym_next         = sym_reg;
        end_next         = end_reg;
        wr_en            = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_kind_next      = m_kind_reg;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        s_ready          = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                sym_next = s_symbol;
                end_next = s_line_end;
            end
            S_EXEC: begin
                if (need_emit) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_last_next  = 1'b1;
                        if (end_reg) begin
                            m_kind_next      = failed_reg ? KIND_DISCARD : KIND_BALANCED;
                            m_character_next = '0;
                            count_next       = '0;
                            failed_next      = 1'b0;
                        end else begin
                            m_kind_next      = dec.is_open ? KIND_OVERFLOW : KIND_CORRUPT;
                            m_character_next = sym_reg;
                            failed_next      = 1'b1;
                        end
                    end
                end else if (go_drain) begin
                    drain_next = count_reg;
                    count_next = '0;
                end else if (!end_reg && !failed_reg) begin
                    if (dec.is_open) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        count_next = count_m1;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_kind_next      = KIND_CLOSE;
                    m_character_next = closer_of(rd_data_reg);
                    m_last_next      = drain_reg == CW'(1);
                    drain_next       = drain_m1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            drain_reg   <= '0;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
        sym_reg         <= sym_next;
        end_reg         <= end_next;
        m_kind_reg      <= m_kind_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

endmodule

FILE: verif/bracket_matcher_completer_core_tb.sv
// Self-checking testbench for the bracket matcher/completer core.
`timescale 1ns / 1ps

module bracket_matcher_completer_core_tb;

    import bmc_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] character;
        logic       last;
    } bmc_out_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_symbol    = 8'h00;
    logic       s_line_end  = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_character;
    logic       m_last;

    // stimulus pacing, in percent
    int gap_pct  = 0;
    int hold_pct = 0;

    // model of the open-bracket stack
    logic [1:0] open_kinds [DEPTH];
    int         open_depth = 0;
    bit         line_bad   = 1'b0;

    bmc_out_t owed_results [$];
    int       items_live      = 0;
    int       results_checked = 0;
    int       result_errors   = 0;

    always #5 aclk = ~aclk;

    bracket_matcher_completer_core #(
        .STACK_DEPTH (DEPTH)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_symbol    (s_symbol),
        .s_line_end  (s_line_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_character (m_character),
        .m_last      (m_last)
    );

    function automatic int open_code(input logic [7:0] c);
        case (c)
            "(": return 0;
            "[": return 1;
            "{": return 2;
            "<": return 3;
            default: return -1;
        endcase
    endfunction

    function automatic int close_code(input logic [7:0] c);
        case (c)
            ")": return 0;
            "]": return 1;
            "}": return 2;
            ">": return 3;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] opener_sym(input logic [1:0] code);
        case (code)
            2'd0: return "(";
            2'd1: return "[";
            2'd2: return "{";
            default: return "<";
        endcase
    endfunction

    function automatic logic [7:0] closer_sym(input logic [1:0] code);
        case (code)
            2'd0: return ")";
            2'd1: return "]";
            2'd2: return "}";
            default: return ">";
        endcase
    endfunction

    function automatic bit is_bracket(input logic [7:0] c);
        return open_code(c) >= 0 || close_code(c) >= 0;
    endfunction

    task automatic owe(input logic [2:0] kind, input logic [7:0] ch, input logic last);
        bmc_out_t r;
        r.kind      = kind;
        r.character = ch;
        r.last      = last;
        owed_results = {owed_results, r};
    endtask

    // advance the stack model by one accepted item
    task automatic walk_symbol(input logic [7:0] sym, input logic le);
        int oc;
        int cc;
        oc = open_code(sym);
        cc = close_code(sym);
        if (le) begin
            if (line_bad) begin
                owe(KIND_DISCARD, 8'h00, 1'b1);
            end else if (open_depth == 0) begin
                owe(KIND_BALANCED, 8'h00, 1'b1);
            end else begin
                for (int i = open_depth - 1; i >= 0; i--)
                    owe(KIND_CLOSE, closer_sym(open_kinds[i]), i == 0);
            end
            open_depth = 0;
            line_bad   = 1'b0;
        end else if (!line_bad) begin
            if (oc >= 0) begin
                if (open_depth >= DEPTH) begin
                    owe(KIND_OVERFLOW, sym, 1'b1);
                    line_bad = 1'b1;
                end else begin
                    open_kinds[open_depth] = oc[1:0];
                    open_depth++;
                end
            end else if (cc >= 0 && open_depth > 0 && open_kinds[open_depth-1] == cc[1:0]) begin
                open_depth--;
            end else begin
                owe(KIND_CORRUPT, sym, 1'b1);
                line_bad = 1'b1;
            end
        end
    endtask

    task automatic send_item(input logic [7:0] sym, input logic le);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_symbol   <= sym;
        s_line_end <= le;
        do @(posedge aclk); while (!s_ready);
        if (le || !line_bad)
            items_live++;
        walk_symbol(sym, le);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], 1'b0);
    endtask

    // hold off the sender until every owed result is out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (owed_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(8'hFF, 1'b1);
        send_text("([{<");
        send_item(8'h00, 1'b1);
        send_text(")(");
        send_item(8'hA5, 1'b1);
        send_text("(]");
        send_item(8'h5A, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h3C, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h29, 1'b1);
        send_text("<{}>[]");
        send_item(8'h7F, 1'b1);
    endtask

    // full stack: overflow, and pop/push at the top then complete 64 deep
    task automatic test_stack_limits();
        logic [1:0] kinds [$];
        logic [1:0] w;
        for (int r = 1; r < 3; r++) begin
            kinds.delete();
            for (int i = 0; i < DEPTH; i++) begin
                w = 2'($urandom_range(3));
                kinds = {kinds, w};
                send_item(opener_sym(w), 1'b0);
            end
            if (r == 1) begin
                send_item(opener_sym(2'($urandom_range(3))), 1'b0);
                send_item(closer_sym(kinds[$]), 1'b0);
            end else if (r == 2) begin
                send_item(closer_sym(kinds.pop_back()), 1'b0);
                send_item(opener_sym(2'($urandom_range(3))), 1'b0);
            end
            send_item(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic send_random_line();
        logic [1:0] stack_kinds [$];
        logic [1:0] w;
        logic [7:0] c;
        int         mode;
        int         len;
        mode = $urandom_range(0, 59);
        if (mode >= 58)
            len = DEPTH;
        else if (mode < 52 && $urandom_range(0, 7) == 0)
            len = $urandom_range(12, 40);
        else
            len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            if (mode >= 58 || stack_kinds.size() == 0 || $urandom_range(99) < 55) begin
                w = 2'($urandom_range(3));
                stack_kinds = {stack_kinds, w};
                send_item(opener_sym(w), 1'b0);
            end else begin
                send_item(closer_sym(stack_kinds.pop_back()), 1'b0);
            end
        end
        if (mode < 40) begin
            if ($urandom_range(2) == 0)
                while (stack_kinds.size() != 0)
                    send_item(closer_sym(stack_kinds.pop_back()), 1'b0);
        end else if (mode < 46) begin
            if (stack_kinds.size() != 0)
                w = stack_kinds[$] + 2'($urandom_range(1, 3));
            else
                w = 2'($urandom_range(3));
            send_item(closer_sym(w), 1'b0);
        end else if (mode < 52) begin
            do c = 8'($urandom_range(255)); while (is_bracket(c));
            send_item(c, 1'b0);
        end else if (mode < 58) begin
            repeat ($urandom_range(1, 6))
                send_item(8'($urandom_range(255)), 1'b0);
        end else if (mode == 59) begin
            send_item(opener_sym(2'($urandom_range(3))), 1'b0);
        end
        if (mode >= 40 && mode != 58)
            repeat ($urandom_range(0, 3))
                send_item(8'($urandom_range(255)), 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic test_random_lines(input int gap, input int hold, input int quota);
        int start;
        gap_pct  = gap;
        hold_pct = hold;
        start    = items_live;
        while (items_live - start < quota)
            send_random_line();
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected item kind %0d char %02h last %0d",
                         $time, m_kind, m_character, m_last);
                result_errors++;
            end else begin
                bmc_out_t w;
                w = owed_results.pop_front();
                results_checked++;
                if (m_kind !== w.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, w.kind, m_kind);
                    result_errors++;
                end
                if (m_character !== w.character) begin
                    $display("%0t: character exp %02h got %02h",
                             $time, w.character, m_character);
                    result_errors++;
                end
                if (m_last !== w.last) begin
                    $display("%0t: last exp %0d got %0d", $time, w.last, m_last);
                    result_errors++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= hold_pct);
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        drain_results();
        hold_pct = 58;
        test_stack_limits();
        drain_results();
        test_random_lines(0, 0, 40);
        test_random_lines(58, 0, 40);
        test_random_lines(0, 58, 40);
        test_random_lines(27, 27, 40);
        repeat (20) @(posedge aclk);
        $display("%0d live items sent: directed lines, full-stack lines, four pacing phases",
                 items_live);
        $display("%0d result items compared, %0d field errors", results_checked, result_errors);
        if (result_errors == 0 && owed_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
src/bmc_pkg.sv
src/bracket_matcher_completer_core.sv
verif/bracket_matcher_completer_core_tb.sv
